// ----- rtl/lps_pkg.sv -----
`timescale 1ns / 1ps

package lps_pkg;

    localparam int COORD_BITS_DEFAULT = 13;
    localparam int SIZE_BITS          = 13;
    localparam int COLOR_BITS         = 32;
    localparam int ADDR_BITS          = 24;
    localparam int CFG_INDEX_BITS     = 2;
    localparam int CFG_DATA_BITS      = 32;
    localparam int QUEUE_DEPTH        = 4;

    localparam logic [SIZE_BITS-1:0]  CANVAS_WIDTH_RESET  = 13'd640;
    localparam logic [SIZE_BITS-1:0]  CANVAS_HEIGHT_RESET = 13'd480;
    localparam logic [COLOR_BITS-1:0] LINE_COLOR_RESET    = 32'hFF00FF00;

    typedef enum logic {
        CMD_START   = 1'b0,
        CMD_ADVANCE = 1'b1
    } cmd_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_CANVAS_WIDTH  = 2'd0,
        REG_CANVAS_HEIGHT = 2'd1,
        REG_LINE_COLOR    = 2'd2
    } cfg_reg_t;

    // Handshake between the stepper and the pixel queue.
    typedef struct packed {
        logic push;
        logic full;
    } queue_wr_t;

endpackage

// ----- rtl/line_pixel_stepper_top.sv -----
`timescale 1ns / 1ps
// Channel   Handshake          Accepted when         Carries
// command   push / full        push && !full         command, x_start, y_start, x_end, y_end
// pixel     empty / pop        pop && !empty         pixel_x/y, address, color, flags
// config    cfg_write          cfg_write             cfg_index, cfg_data
//
// One command is taken per cycle while the pixel queue is not full; the Bresenham
// step of the stepper, one add and compare per axis, sets that rate. A pixel
// enters the pixel queue at the edge that takes its command, then passes the row
// multiply and the address add, one register each, on its way to the result ports.
// Reset leaves the stepper idle with the configuration at its reset values.
// A stalled result side fills the four-beat pixel queue, after which full rises.

module line_pixel_stepper_top #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [lps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [lps_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic                                command,
    input  logic signed [COORD_BITS-1:0]        x_start,
    input  logic signed [COORD_BITS-1:0]        y_start,
    input  logic signed [COORD_BITS-1:0]        x_end,
    input  logic signed [COORD_BITS-1:0]        y_end,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [COORD_BITS-1:0]        pixel_x,
    output logic signed [COORD_BITS-1:0]        pixel_y,
    output logic [lps_pkg::ADDR_BITS-1:0]       pixel_address,
    output logic [lps_pkg::COLOR_BITS-1:0]      pixel_color,
    output logic                                in_canvas,
    output logic                                last_pixel
);
    import lps_pkg::*;

    localparam int ITEM_W = 2 * COORD_BITS + 1;

    logic [SIZE_BITS-1:0]  canvas_width_reg;
    logic [SIZE_BITS-1:0]  canvas_height_reg;
    logic [COLOR_BITS-1:0] line_color_reg;

    queue_wr_t             q_wr;
    logic                  q_full;
    logic                  q_empty;
    logic                  q_pop;
    logic [ITEM_W-1:0]     q_wr_data;
    logic [ITEM_W-1:0]     q_rd_data;
    logic                  front_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg  <= CANVAS_WIDTH_RESET;
            canvas_height_reg <= CANVAS_HEIGHT_RESET;
            line_color_reg    <= LINE_COLOR_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_CANVAS_WIDTH)
            begin
                canvas_width_reg <= cfg_data[SIZE_BITS-1:0];
            end
            if (cfg_index == REG_CANVAS_HEIGHT)
            begin
                canvas_height_reg <= cfg_data[SIZE_BITS-1:0];
            end
            if (cfg_index == REG_LINE_COLOR)
            begin
                line_color_reg <= cfg_data[COLOR_BITS-1:0];
            end
        end
    end

    lps_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .command (command),
        .x_start (x_start),
        .y_start (y_start),
        .x_end   (x_end),
        .y_end   (y_end),
        .q_wr    (q_wr),
        .q_full  (q_full),
        .q_data  (q_wr_data),
        .busy    (front_busy)
    );

    lps_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_wr.push),
        .push_data (q_wr_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rd_data),
        .empty     (q_empty)
    );

    lps_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_data        (q_rd_data),
        .q_pop         (q_pop),
        .canvas_width  (canvas_width_reg),
        .canvas_height (canvas_height_reg),
        .empty         (empty),
        .pop           (pop),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_address (pixel_address),
        .in_canvas     (in_canvas),
        .last_pixel    (last_pixel)
    );

    // The user must keep the colour static while a line is drawn; the block does not enforce it.
    assign pixel_color = line_color_reg;

    a_neg_not_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && in_canvas) |-> (!pixel_x[COORD_BITS-1] && !pixel_y[COORD_BITS-1]))
        else $error("pixel with a negative coordinate flagged in canvas");

    a_addr_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !in_canvas) |-> (pixel_address == '0))
        else $error("off-canvas pixel carries a non-zero address");

    a_single_point_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && command == CMD_START && x_start == x_end && y_start == y_end)
        |=> !front_busy)
        else $error("stepper busy after a single-point line");

    a_queue_flag: assert property (@(posedge clk) disable iff (!rst_n)
        q_wr.full == q_full)
        else $error("queue status mismatch between stepper and queue");

endmodule

// ----- rtl/lps_queue.sv -----
`timescale 1ns / 1ps

module lps_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/lps_front.sv -----
`timescale 1ns / 1ps

module lps_front #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         command,
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    output lps_pkg::queue_wr_t           q_wr,
    input  logic                         q_full,
    output logic [2*COORD_BITS:0]        q_data,
    output logic                         busy
);
    import lps_pkg::*;

    localparam int DW  = COORD_BITS + 1;
    localparam int EW  = COORD_BITS + 2;
    localparam int E2W = COORD_BITS + 3;

    logic signed [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic signed [COORD_BITS-1:0] goal_x_reg, goal_x_next;
    logic signed [COORD_BITS-1:0] goal_y_reg, goal_y_next;
    logic signed [DW-1:0]         delta_x_reg, delta_x_next;
    logic signed [DW-1:0]         delta_y_reg, delta_y_next;
    logic                         step_x_neg_reg, step_x_neg_next;
    logic                         step_y_neg_reg, step_y_neg_next;
    logic signed [EW-1:0]         error_reg, error_next;
    logic                         busy_reg, busy_next;

    logic                         accept;
    logic                         is_start;
    logic                         emit;
    logic signed [DW-1:0]         x0_w, y0_w, x1_w, y1_w;
    logic signed [DW-1:0]         dx_start, dy_start;
    logic signed [E2W-1:0]        e2;
    logic                         move_x, move_y;
    logic signed [COORD_BITS-1:0] adv_x, adv_y;
    logic signed [EW-1:0]         adv_error;
    logic                         last;

    assign full     = q_full;
    assign accept   = push && !q_full;
    assign is_start = (command == CMD_START);
    assign emit     = accept && (is_start || busy_reg);
    assign busy     = busy_reg;

    assign q_wr.push = emit;
    assign q_wr.full = q_full;

    assign x0_w = DW'(x_start);
    assign y0_w = DW'(y_start);
    assign x1_w = DW'(x_end);
    assign y1_w = DW'(y_end);
    assign dx_start = (x1_w > x0_w) ? (x1_w - x0_w) : (x0_w - x1_w);
    assign dy_start = (y1_w > y0_w) ? (y1_w - y0_w) : (y0_w - y1_w);

    // One Bresenham step: the doubled error decides which axes move.
    assign e2     = signed'({error_reg, 1'b0});
    assign move_x = e2 > -E2W'(delta_y_reg);
    assign move_y = e2 < E2W'(delta_x_reg);
    assign adv_x  = move_x ? (step_x_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1)
                           : cur_x_reg;
    assign adv_y  = move_y ? (step_y_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1)
                           : cur_y_reg;
    assign adv_error = error_reg - (move_x ? EW'(delta_y_reg) : EW'(0))
                                 + (move_y ? EW'(delta_x_reg) : EW'(0));

    always_comb
    begin
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        goal_x_next     = goal_x_reg;
        goal_y_next     = goal_y_reg;
        delta_x_next    = delta_x_reg;
        delta_y_next    = delta_y_reg;
        step_x_neg_next = step_x_neg_reg;
        step_y_neg_next = step_y_neg_reg;
        error_next      = error_reg;
        busy_next       = busy_reg;
        if (accept && is_start)
        begin
            cur_x_next      = x_start;
            cur_y_next      = y_start;
            goal_x_next     = x_end;
            goal_y_next     = y_end;
            delta_x_next    = dx_start;
            delta_y_next    = dy_start;
            step_x_neg_next = !(x0_w < x1_w);
            step_y_neg_next = !(y0_w < y1_w);
            error_next      = EW'(dx_start) - EW'(dy_start);
        end
        else if (accept && busy_reg)
        begin
            cur_x_next = adv_x;
            cur_y_next = adv_y;
            error_next = adv_error;
        end
        last = (cur_x_next == goal_x_next) && (cur_y_next == goal_y_next);
        if (emit)
        begin
            busy_next = !last;
        end
    end

    assign q_data = {cur_x_next, cur_y_next, last};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg      <= cur_x_next;
        cur_y_reg      <= cur_y_next;
        goal_x_reg     <= goal_x_next;
        goal_y_reg     <= goal_y_next;
        delta_x_reg    <= delta_x_next;
        delta_y_reg    <= delta_y_next;
        step_x_neg_reg <= step_x_neg_next;
        step_y_neg_reg <= step_y_neg_next;
        error_reg      <= error_next;
    end

endmodule

// ----- rtl/lps_back.sv -----
`timescale 1ns / 1ps

module lps_back #(
    parameter int COORD_BITS = lps_pkg::COORD_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_empty,
    input  logic [2*COORD_BITS:0]            q_data,
    output logic                             q_pop,
    input  logic [lps_pkg::SIZE_BITS-1:0]    canvas_width,
    input  logic [lps_pkg::SIZE_BITS-1:0]    canvas_height,
    output logic                             empty,
    input  logic                             pop,
    output logic signed [COORD_BITS-1:0]     pixel_x,
    output logic signed [COORD_BITS-1:0]     pixel_y,
    output logic [lps_pkg::ADDR_BITS-1:0]    pixel_address,
    output logic                             in_canvas,
    output logic                             last_pixel
);
    import lps_pkg::*;

    localparam int CMP_W  = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
    localparam int PROD_W = COORD_BITS + SIZE_BITS;
    localparam int SUM_W  = (PROD_W > ADDR_BITS) ? PROD_W : ADDR_BITS;

    logic [COORD_BITS-1:0] qx, qy;
    logic                  qlast;
    logic                  q_inside;

    // Stage A: bounds check and row product.
    logic                  a_valid_reg;
    logic [COORD_BITS-1:0] a_x_reg, a_y_reg;
    logic                  a_last_reg, a_inside_reg;
    logic [PROD_W-1:0]     a_prod_reg;

    // Stage B: address sum, held on the result ports.
    logic                  b_valid_reg;
    logic [COORD_BITS-1:0] b_x_reg, b_y_reg;
    logic [ADDR_BITS-1:0]  b_addr_reg;
    logic                  b_last_reg, b_inside_reg;

    logic                  adv_a;
    logic                  adv_b;
    logic [SUM_W-1:0]      addr_sum;

    assign {qx, qy, qlast} = q_data;

    assign q_inside = !qx[COORD_BITS-1] && !qy[COORD_BITS-1]
                   && (CMP_W'(qx) < CMP_W'(canvas_width))
                   && (CMP_W'(qy) < CMP_W'(canvas_height));

    assign adv_b = !b_valid_reg || pop;
    assign adv_a = !a_valid_reg || adv_b;
    assign q_pop = adv_a && !q_empty;

    assign addr_sum = SUM_W'(a_prod_reg) + SUM_W'(a_x_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_a)
            begin
                a_valid_reg <= !q_empty;
            end
            if (adv_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_x_reg      <= qx;
            a_y_reg      <= qy;
            a_last_reg   <= qlast;
            a_inside_reg <= q_inside;
            a_prod_reg   <= PROD_W'(qy) * PROD_W'(canvas_width);
        end
        if (adv_b && a_valid_reg)
        begin
            b_x_reg      <= a_x_reg;
            b_y_reg      <= a_y_reg;
            b_last_reg   <= a_last_reg;
            b_inside_reg <= a_inside_reg;
            b_addr_reg   <= a_inside_reg ? addr_sum[ADDR_BITS-1:0] : '0;
        end
    end

    assign empty         = !b_valid_reg;
    assign pixel_x       = signed'(b_x_reg);
    assign pixel_y       = signed'(b_y_reg);
    assign pixel_address = b_addr_reg;
    assign in_canvas     = b_inside_reg;
    assign last_pixel    = b_last_reg;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    import lps_pkg::*;

    localparam int COORD_W = COORD_BITS_DEFAULT;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [ADDR_BITS-1:0]      address;
        logic [COLOR_BITS-1:0]     color;
        logic                      on_canvas;
        logic                      is_last;
    } pixel_t;

    typedef struct {
        cmd_t   cmd;
        int     x0;
        int     y0;
        int     x1;
        int     y1;
        bit     typed;
        pixel_t want;
    } beat_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0]    cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]     cfg_data = '0;
    logic                         push = 1'b0;
    logic                         full;
    logic                         command = 1'b0;
    logic signed [COORD_W-1:0]    x_start = '0;
    logic signed [COORD_W-1:0]    y_start = '0;
    logic signed [COORD_W-1:0]    x_end = '0;
    logic signed [COORD_W-1:0]    y_end = '0;
    logic                         empty;
    logic                         pop = 1'b0;
    logic signed [COORD_W-1:0]    pixel_x;
    logic signed [COORD_W-1:0]    pixel_y;
    logic [ADDR_BITS-1:0]         pixel_address;
    logic [COLOR_BITS-1:0]        pixel_color;
    logic                         in_canvas;
    logic                         last_pixel;

    // Our own copy of the stepper state and of its registers.
    logic signed [COORD_W-1:0]    pos_x = '0, pos_y = '0, tgt_x = '0, tgt_y = '0;
    logic [COORD_W:0]             span_x = '0, span_y = '0;
    logic signed [COORD_W+1:0]    err_acc = '0;
    bit                           walk_x_down = 1'b0, walk_y_down = 1'b0;
    bit                           drawing = 1'b0;
    logic [SIZE_BITS-1:0]         canvas_w = CANVAS_WIDTH_RESET;
    logic [SIZE_BITS-1:0]         canvas_h = CANVAS_HEIGHT_RESET;
    logic [COLOR_BITS-1:0]        ink = LINE_COLOR_RESET;

    pixel_t pending_pixels[$];
    beat_t  directed_rows[$];
    pixel_t popped;
    int     mismatches = 0;
    int     sender_idle = 0;
    int     recv_idle = 0;

    line_pixel_stepper_top #(.COORD_BITS(COORD_W)) dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 50)
            $display("mismatch at %0t ns: %s", $time, what);
    endtask

    function automatic int clamp_coord(input int v);
        if (v < -4096)
            return -4096;
        if (v > 4095)
            return 4095;
        return v;
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(0, 8191)) - 4096;
    endfunction

    // Coordinates near the origin or near the far canvas edge, else anywhere.
    function automatic int pick_coord(input int size);
        case ($urandom_range(0, 3))
            0: return clamp_coord(int'($urandom_range(0, 63)) - 8);
            1: return clamp_coord(size - 8 + int'($urandom_range(0, 15)));
            default: return rand_coord();
        endcase
    endfunction

    function automatic bit predict_pixel(input cmd_t cmd,
            input logic signed [COORD_W-1:0] x0, y0, x1, y1, output pixel_t px);
        int dx;
        int dy;
        int twice;
        int sum;
        if (cmd == CMD_START)
        begin
            pos_x = x0;
            pos_y = y0;
            tgt_x = x1;
            tgt_y = y1;
            dx = int'(x1) - int'(x0);
            dy = int'(y1) - int'(y0);
            span_x = (COORD_W+1)'(dx < 0 ? -dx : dx);
            span_y = (COORD_W+1)'(dy < 0 ? -dy : dy);
            walk_x_down = !(x0 < x1);
            walk_y_down = !(y0 < y1);
            err_acc = (COORD_W+2)'(int'(span_x) - int'(span_y));
        end
        else
        begin
            if (!drawing)
                return 1'b0;
            twice = 2 * int'(err_acc);
            if (twice > -int'(span_y))
            begin
                err_acc = (COORD_W+2)'(int'(err_acc) - int'(span_y));
                pos_x = walk_x_down ? pos_x - 1'b1 : pos_x + 1'b1;
            end
            if (twice < int'(span_x))
            begin
                err_acc = (COORD_W+2)'(int'(err_acc) + int'(span_x));
                pos_y = walk_y_down ? pos_y - 1'b1 : pos_y + 1'b1;
            end
        end
        px.x = pos_x;
        px.y = pos_y;
        px.on_canvas = pos_x >= 0 && pos_y >= 0 &&
                       int'(pos_x) < int'(canvas_w) && int'(pos_y) < int'(canvas_h);
        sum = int'(pos_y) * int'(canvas_w) + int'(pos_x);
        px.address = px.on_canvas ? ADDR_BITS'(sum) : '0;
        px.color = ink;
        px.is_last = pos_x == tgt_x && pos_y == tgt_y;
        drawing = !px.is_last;
        return 1'b1;
    endfunction

    task automatic add_row(input cmd_t c, input int x0, y0, x1, y1, input bit typed,
            input int wx, wy, waddr, input bit win, wlast);
        beat_t r;
        r.cmd = c;
        r.x0 = x0;
        r.y0 = y0;
        r.x1 = x1;
        r.y1 = y1;
        r.typed = typed;
        r.want.x = COORD_W'(wx);
        r.want.y = COORD_W'(wy);
        r.want.address = ADDR_BITS'(waddr);
        r.want.color = LINE_COLOR_RESET;
        r.want.on_canvas = win;
        r.want.is_last = wlast;
        directed_rows.push_back(r);
    endtask

    // Called just after a rising edge; returns at the edge that takes the beat.
    task automatic send_beat(input beat_t b);
        pixel_t px;
        while ($urandom_range(0, 99) < sender_idle)
        begin
            push    <= 1'b0;
            command <= 1'($urandom);
            x_start <= COORD_W'($urandom);
            y_start <= COORD_W'($urandom);
            x_end   <= COORD_W'($urandom);
            y_end   <= COORD_W'($urandom);
            @(posedge clk);
        end
        push    <= 1'b1;
        command <= b.cmd;
        x_start <= COORD_W'(b.x0);
        y_start <= COORD_W'(b.y0);
        x_end   <= COORD_W'(b.x1);
        y_end   <= COORD_W'(b.y1);
        @(posedge clk);
        while (full !== 1'b0)
            @(posedge clk);
        if (predict_pixel(b.cmd, COORD_W'(b.x0), COORD_W'(b.y0),
                          COORD_W'(b.x1), COORD_W'(b.y1), px))
            pending_pixels.push_back(b.typed ? b.want : px);
    endtask

    task automatic drain_pixels();
        push <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic configure(input logic [31:0] w, h, c, input bit poke_spare);
        logic [CFG_INDEX_BITS-1:0] idx[4];
        logic [31:0]               val[4];
        int                        n;
        idx[0] = REG_CANVAS_WIDTH;
        val[0] = w;
        idx[1] = REG_CANVAS_HEIGHT;
        val[1] = h;
        idx[2] = REG_LINE_COLOR;
        val[2] = c;
        idx[3] = REG_SPARE;
        val[3] = $urandom;
        n = poke_spare ? 4 : 3;
        for (int i = 0; i < n; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            case (idx[i])
                REG_CANVAS_WIDTH:  canvas_w = val[i][SIZE_BITS-1:0];
                REG_CANVAS_HEIGHT: canvas_h = val[i][SIZE_BITS-1:0];
                REG_LINE_COLOR:    ink = val[i];
                default: ;
            endcase
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    // Mostly whole lines with random endpoints: a start and then one advance
    // per further pixel, now and then cut short, overrun or replaced by a stray advance.
    task automatic run_lines(input int target);
        beat_t b;
        int    sent;
        int    steps;
        int    dx;
        int    dy;
        bit    paused;
        sent = 0;
        paused = 1'b0;
        b.typed = 1'b0;
        while (sent < target)
        begin
            if (!paused && sent >= target / 2)
            begin
                drain_pixels();
                paused = 1'b1;
            end
            if ($urandom_range(0, 19) == 0)
            begin
                b.cmd = CMD_ADVANCE;
                b.x0 = rand_coord();
                b.y0 = rand_coord();
                b.x1 = rand_coord();
                b.y1 = rand_coord();
                send_beat(b);
                sent++;
            end
            else
            begin
                b.cmd = CMD_START;
                b.x0 = pick_coord(int'(canvas_w));
                b.y0 = pick_coord(int'(canvas_h));
                if ($urandom_range(0, 15) == 0)
                begin
                    b.x1 = rand_coord();
                    b.y1 = rand_coord();
                end
                else
                begin
                    b.x1 = clamp_coord(b.x0 + int'($urandom_range(0, 24)) - 12);
                    b.y1 = clamp_coord(b.y0 + int'($urandom_range(0, 24)) - 12);
                end
                dx = b.x1 > b.x0 ? b.x1 - b.x0 : b.x0 - b.x1;
                dy = b.y1 > b.y0 ? b.y1 - b.y0 : b.y0 - b.y1;
                steps = dx > dy ? dx : dy;
                case ($urandom_range(0, 9))
                    0: steps = $urandom_range(0, steps);
                    1: steps = steps + int'($urandom_range(1, 3));
                    default: ;
                endcase
                if (steps > 60)
                    steps = $urandom_range(0, 60);
                send_beat(b);
                sent++;
                repeat (steps)
                begin
                    b.cmd = CMD_ADVANCE;
                    b.x0 = rand_coord();
                    b.y0 = rand_coord();
                    b.x1 = rand_coord();
                    b.y1 = rand_coord();
                    send_beat(b);
                    sent++;
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pending_pixels.size() == 0)
                    report_mismatch("pixel beat arrived with nothing expected");
                else
                begin
                    popped = pending_pixels.pop_front();
                    if (pixel_x !== popped.x)
                        report_mismatch($sformatf("pixel_x got %0d want %0d",
                                                  pixel_x, popped.x));
                    if (pixel_y !== popped.y)
                        report_mismatch($sformatf("pixel_y got %0d want %0d",
                                                  pixel_y, popped.y));
                    if (pixel_address !== popped.address)
                        report_mismatch($sformatf("pixel_address got %0h want %0h",
                                                  pixel_address, popped.address));
                    if (pixel_color !== popped.color)
                        report_mismatch($sformatf("pixel_color got %0h want %0h",
                                                  pixel_color, popped.color));
                    if (in_canvas !== popped.on_canvas)
                        report_mismatch($sformatf("in_canvas got %0b want %0b",
                                                  in_canvas, popped.on_canvas));
                    if (last_pixel !== popped.is_last)
                        report_mismatch($sformatf("last_pixel got %0b want %0b",
                                                  last_pixel, popped.is_last));
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Advance while idle, single-pixel lines at the canvas corners and the
        // coordinate extremes, lines that step in several directions (none with both
        // coordinates falling), a restart while a line is being drawn, and equal endpoints on one axis.
        add_row(CMD_ADVANCE, 4095, -1, -4096, 1, 1'b0, 0, 0, 0, 1'b0, 1'b0);
        add_row(CMD_START, 0, 0, 0, 0, 1'b1, 0, 0, 0, 1'b1, 1'b1);
        add_row(CMD_START, 639, 479, 639, 479, 1'b1, 639, 479, 307199, 1'b1, 1'b1);
        add_row(CMD_START, 640, 0, 640, 0, 1'b1, 640, 0, 0, 1'b0, 1'b1);
        add_row(CMD_START, -4096, -4096, -4096, -4096, 1'b1, -4096, -4096, 0, 1'b0, 1'b1);
        add_row(CMD_START, 4095, 4095, 4095, 4095, 1'b1, 4095, 4095, 0, 1'b0, 1'b1);
        add_row(CMD_ADVANCE, -1, -1, -1, -1, 1'b0, 0, 0, 0, 1'b0, 1'b0);
        add_row(CMD_START, -4096, 4095, -4095, 4094, 1'b0, 0, 0, 0, 1'b0, 1'b0);
        add_row(CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 1'b0);
        add_row(CMD_START, 4095, -4096, 4093, -4095, 1'b0, 0, 0, 0, 1'b0, 1'b0);
        add_row(CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 1'b0);
        add_row(CMD_ADVANCE, -1, -1, -1, -1, 1'b0, 0, 0, 0, 1'b0, 1'b0);
        add_row(CMD_START, 5, 5, 5, 8, 1'b0, 0, 0, 0, 1'b0, 1'b0);
        add_row(CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 1'b0);
        add_row(CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 1'b0);
        add_row(CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 1'b0);
        add_row(CMD_START, 0, 0, 100, 37, 1'b0, 0, 0, 0, 1'b0, 1'b0);
        add_row(CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 1'b0);
        add_row(CMD_START, 7, 3, 6, 3, 1'b0, 0, 0, 0, 1'b0, 1'b0);
        add_row(CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 1'b0);
        add_row(CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0, 1'b0);

        sender_idle = 33;
        recv_idle = 47;
        foreach (directed_rows[i])
            send_beat(directed_rows[i]);

        for (int ph = 0; ph < 6; ph++)
        begin
            drain_pixels();
            // A trailing advance on an idle stepper may still be in flight.
            repeat (8) @(posedge clk);
            case (ph)
                0: configure(32'd1, 32'd1, 32'h0000_0000, 1'b0);
                1: configure(32'd4096, 32'd4096, 32'hFFFF_FFFF, 1'b0);
                2: configure(32'd0, 32'd4096, $urandom, 1'b1);
                3: configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom, 1'b0);
                4: configure($urandom_range(1, 4096), $urandom_range(1, 4096),
                             $urandom, 1'b1);
                default: configure(32'd640, 32'd480, $urandom, 1'b0);
            endcase
            case (ph / 2)
                0:
                begin
                    sender_idle = 33;
                    recv_idle = 47;
                end
                1:
                begin
                    sender_idle = 47;
                    recv_idle = 33;
                end
                default:
                begin
                    sender_idle = 0;
                    recv_idle = 0;
                end
            endcase
            run_lines(150);
        end

        drain_pixels();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
